/* hdl/fwkr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with keyed removal - shared definitions
// Default sizes, operation codes, controller states and the command and
// status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package fwkr_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int FIELD_BITS  = 32;
  localparam int LENGTH_BITS = 5;
  localparam int OP_BITS     = 2;

  typedef logic [OP_BITS-1:0] op_t;

  localparam op_t OP_ENQUEUE = 2'd0;
  localparam op_t OP_DEQUEUE = 2'd1;
  localparam op_t OP_REMOVE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clr_result;
    logic enq_write;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic rd_next;
    logic shift_write;
    logic take;
    logic set_ok;
    logic fill_inc;
    logic fill_dec;
    logic load_out;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic key_match;
    logic more1;
    logic more2;
  } stat_t;

endpackage

/* hdl/fwkr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with keyed removal - channel interfaces
// Request channel (operation, key, payload) and response channel (status,
// removed entry, fill level), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwkr_req_if
  import fwkr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    op;
  logic [FIELD_BITS-1:0] entry_key;
  logic [FIELD_BITS-1:0] entry_payload;

  modport source (output valid, output op, output entry_key, output entry_payload,
                  input ready);
  modport sink   (input valid, input op, input entry_key, input entry_payload,
                  output ready);
endinterface

interface fwkr_rsp_if
  import fwkr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [FIELD_BITS-1:0]  out_key;
  logic [FIELD_BITS-1:0]  out_payload;
  logic [LENGTH_BITS-1:0] length;
  logic                   not_empty;

  modport source (output valid, output ok, output out_key, output out_payload,
                  output length, output not_empty, input ready);
  modport sink   (input valid, input ok, input out_key, input out_payload,
                  input length, input not_empty, output ready);
endinterface

/* hdl/fwkr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with keyed removal - generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fwkr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/fwkr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with keyed removal - controller
// Sequences enqueue, scan, compaction and response hand-off.
// ----------------------------------------------------------------------------
module fwkr_ctrl
  import fwkr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   match;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    ctrl       = '0;
    state_next = state;
    req_ready  = (state == ST_IDLE);
    // A dequeue takes the oldest entry whatever its key.
    match      = (stat.op == OP_DEQUEUE) || stat.key_match;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctrl.capture = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        ctrl.clr_result = 1'b1;
        ctrl.idx_clr    = 1'b1;
        case (stat.op)
          OP_ENQUEUE: begin
            if (!stat.full) begin
              ctrl.enq_write = 1'b1;
              ctrl.fill_inc  = 1'b1;
              ctrl.set_ok    = 1'b1;
            end
            state_next = ST_FINISH;
          end
          OP_DEQUEUE, OP_REMOVE: begin
            state_next = stat.empty ? ST_FINISH : ST_SCAN_RD;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_SCAN_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (match) begin
          ctrl.take = 1'b1;
          if (stat.more1) begin
            state_next = ST_SHIFT_RD;
          end else begin
            ctrl.fill_dec = 1'b1;
            state_next    = ST_FINISH;
          end
        end else if (stat.more1) begin
          ctrl.idx_inc = 1'b1;
          state_next   = ST_SCAN_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SHIFT_RD: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_next = 1'b1;
        state_next   = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        ctrl.shift_write = 1'b1;
        ctrl.idx_inc     = 1'b1;
        if (stat.more2) begin
          state_next = ST_SHIFT_RD;
        end else begin
          ctrl.fill_dec = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          ctrl.load_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (ctrl.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

/* hdl/fwkr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with keyed removal - datapath
// Entry RAM, fill count, slot index, command registers and response register.
// ----------------------------------------------------------------------------
module fwkr_dp
  import fwkr_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_t                  ctrl,
  output stat_t                  stat,
  input  logic [OP_BITS-1:0]     op,
  input  logic [FIELD_BITS-1:0]  entry_key,
  input  logic [FIELD_BITS-1:0]  entry_payload,
  output logic                   ok,
  output logic [FIELD_BITS-1:0]  out_key,
  output logic [FIELD_BITS-1:0]  out_payload,
  output logic [LENGTH_BITS-1:0] length,
  output logic                   not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  op_t                     cmd_op;
  logic [KEY_BITS-1:0]     cmd_key;
  logic [PAYLOAD_BITS-1:0] cmd_payload;
  logic [CW-1:0]           fill;
  logic [CW-1:0]           idx;
  logic                    res_ok;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_payload;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data;
  logic [AW-1:0]   rd_addr;
  logic [EW-1:0]   rd_data;
  logic [CW:0]     idx_ext;
  logic [CW:0]     fill_ext;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_op      <= op;
      cmd_key     <= KEY_BITS'(entry_key);
      cmd_payload <= PAYLOAD_BITS'(entry_payload);
    end
    if (ctrl.clr_result) begin
      res_ok      <= 1'b0;
      res_key     <= '0;
      res_payload <= '0;
    end
    if (ctrl.set_ok) begin
      res_ok <= 1'b1;
    end
    if (ctrl.take) begin
      res_ok      <= 1'b1;
      res_key     <= rd_data[EW-1:PAYLOAD_BITS];
      res_payload <= rd_data[PAYLOAD_BITS-1:0];
    end
    if (ctrl.load_out) begin
      ok          <= res_ok;
      out_key     <= FIELD_BITS'(res_key);
      out_payload <= FIELD_BITS'(res_payload);
      length      <= LENGTH_BITS'(fill);
      not_empty   <= (fill != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idx  <= '0;
    end else begin
      if (ctrl.fill_inc) begin
        fill <= fill + CW'(1);
      end else if (ctrl.fill_dec) begin
        fill <= fill - CW'(1);
      end
      if (ctrl.idx_clr) begin
        idx <= '0;
      end else if (ctrl.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  assign wr_en   = ctrl.enq_write | ctrl.shift_write;
  assign wr_addr = ctrl.enq_write ? fill[AW-1:0] : idx[AW-1:0];
  assign wr_data = ctrl.enq_write ? {cmd_key, cmd_payload} : rd_data;
  assign rd_addr = ctrl.rd_next ? AW'(idx + CW'(1)) : idx[AW-1:0];

  fwkr_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign idx_ext  = {1'b0, idx};
  assign fill_ext = {1'b0, fill};

  assign stat.op        = cmd_op;
  assign stat.full      = (fill == CW'(DEPTH));
  assign stat.empty     = (fill == '0);
  assign stat.key_match = (rd_data[EW-1:PAYLOAD_BITS] == cmd_key);
  assign stat.more1     = (idx_ext + (CW+1)'(1)) < fill_ext;
  assign stat.more2     = (idx_ext + (CW+1)'(2)) < fill_ext;

endmodule

/* hdl/fifo_with_keyed_removal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with keyed removal - top level
// Bounded queue of key/payload entries with enqueue, dequeue and
// remove-by-key that keeps the order of the remaining entries.
// ----------------------------------------------------------------------------
// Sequence: an enqueue or a no-op passes DISPATCH and FINISH after acceptance.
// A dequeue or remove also walks the slots in use before FINISH:
// every slot is either scanned (RAM read, then compare) or moved
// down one place (RAM read, then write), one step after the other in the RAM.
// Flow: one transaction at a time; FINISH waits while an earlier response is
// still held, then parks the response in the output register and returns to
// idle, so the next request can be taken before that response is taken.
// Reset: synchronous, clears the fill count and the controller; entry RAM is
// not cleared, since only written slots are ever read.
// ----------------------------------------------------------------------------
module fifo_with_keyed_removal
  import fwkr_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  fwkr_req_if.sink  req,
  fwkr_rsp_if.source rsp
);

  // Commands and status between the state machine and the datapath.
  ctrl_t ctrl;
  stat_t stat;

  // The controller owns both handshakes: it accepts a request only when idle
  // and raises response valid when the datapath loads the output register.
  fwkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // The datapath holds the entries in slot order, oldest in slot 0. Removal
  // copies every younger entry one slot down so the order is preserved.
  fwkr_dp #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .op            (req.op),
    .entry_key     (req.entry_key),
    .entry_payload (req.entry_payload),
    .ok            (rsp.ok),
    .out_key       (rsp.out_key),
    .out_payload   (rsp.out_payload),
    .length        (rsp.length),
    .not_empty     (rsp.not_empty)
  );

endmodule
